// ===== hw/rtl/enigma_rotor_cipher_macros.svh =====
// Assertion macros for the rotor cipher block
`ifndef ENIGMA_ROTOR_CIPHER_MACROS_SVH
`define ENIGMA_ROTOR_CIPHER_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define ERC_ASSERT_HOLD(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("erc: invariant violated");

// same-cycle implication
`define ERC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("erc: implication violated");

`endif

// ===== hw/rtl/erc_pkg.sv =====
// Package: types, wiring tables and letter arithmetic for the rotor cipher
`timescale 1ns / 1ps
`default_nettype none
package erc_pkg;

	localparam int ROTOR_COUNT   = 3;
	localparam int ALPHABET_SIZE = 26;
	localparam int WHEEL_COUNT   = 8;
	localparam int REFL_COUNT    = 3;

	localparam logic [4:0] SPACE_CODE = 5'd26;
	localparam logic [4:0] LAST_LETTER = 5'd25;

	localparam logic [2:0] CFG_WHEEL_ORDER      = 3'd0;
	localparam logic [2:0] CFG_REFLECTOR_SELECT = 3'd1;
	localparam logic [2:0] CFG_RING_SETTINGS    = 3'd2;
	localparam logic [2:0] CFG_START_POSITIONS  = 3'd3;
	localparam logic [2:0] CFG_PLUG_PAIRS_A     = 3'd4;
	localparam logic [2:0] CFG_PLUG_PAIRS_B     = 3'd5;

	localparam logic OP_CIPHER = 1'b0;
	localparam logic OP_RELOAD = 1'b1;

	localparam logic [8*ALPHABET_SIZE-1:0] WHEEL_STR [WHEEL_COUNT] = '{
		"EKMFLGDQVZNTOWYHXUSPAIBRCJ",
		"AJDKSIRUXBLHWTMCQGZNPYFVOE",
		"BDFHJLCPRTXVZNYEIWGAKMUSQO",
		"ESOVPZJAYQUIRHXLNFTGKDCMWB",
		"VZBRGITYUPSDNHLXAWMJQOFECK",
		"JPGVOUMFYQBENHZRDKASXLICTW",
		"NZJHGRCXMYSWBOUFAIVLPEKQDT",
		"FKQHTLXOCBJSPDZRAMEWNIUYGV"
	};

	localparam logic [8*ALPHABET_SIZE-1:0] REFL_STR [REFL_COUNT] = '{
		"EJMZALYXVBWFCRQUONTSPIKHGD",
		"YRUHQSLDPXNGOKMIEBFZCWVJAT",
		"FVPJIAOYEDRZXWGCTKUQSBNMHL"
	};

	localparam logic [4:0] TURN_A [WHEEL_COUNT] = '{
		5'd16, 5'd4, 5'd21, 5'd9, 5'd25, 5'd25, 5'd25, 5'd25
	};
	localparam logic [4:0] TURN_B [WHEEL_COUNT] = '{
		5'd16, 5'd4, 5'd21, 5'd9, 5'd25, 5'd12, 5'd12, 5'd12
	};

	typedef struct packed {
		logic [8:0]  wheel_order;
		logic [1:0]  reflector_select;
		logic [14:0] ring_settings;
		logic [14:0] start_positions;
		logic [49:0] plug_pairs_a;
		logic [49:0] plug_pairs_b;
	} erc_cfg_t;

	// one beat handed from the front to the back; shift index 0 is the left rotor
	typedef struct packed {
		logic        letter;
		logic [4:0]  symbol;
		logic [14:0] windows;
		logic [ROTOR_COUNT-1:0][4:0] shift;
	} erc_item_t;

	function automatic logic [4:0] fold26(input logic [4:0] v);
		return (v >= 5'(ALPHABET_SIZE)) ? 5'(v - 5'(ALPHABET_SIZE)) : v;
	endfunction

	function automatic logic [4:0] add26(input logic [4:0] a, input logic [4:0] b);
		logic [5:0] t;
		t = {1'b0, a} + {1'b0, b};
		return (t >= 6'(ALPHABET_SIZE)) ? 5'(t - 6'(ALPHABET_SIZE)) : 5'(t);
	endfunction

	function automatic logic [4:0] sub26(input logic [4:0] a, input logic [4:0] b);
		logic [5:0] t;
		t = {1'b0, a} + 6'(ALPHABET_SIZE) - {1'b0, b};
		return (t >= 6'(ALPHABET_SIZE)) ? 5'(t - 6'(ALPHABET_SIZE)) : 5'(t);
	endfunction

	function automatic logic [4:0] inc26(input logic [4:0] p);
		return (p >= LAST_LETTER) ? 5'd0 : 5'(p + 5'd1);
	endfunction

	function automatic logic [4:0] wheel_fwd(input logic [2:0] w, input logic [4:0] i);
		logic [7:0] ch;
		ch = WHEEL_STR[w][8*(ALPHABET_SIZE-1-int'(i)) +: 8];
		return 5'(ch - 8'd65);
	endfunction

	function automatic logic [4:0] wheel_inv(input logic [2:0] w, input logic [4:0] i);
		logic [4:0] o;
		o = 5'd0;
		for (int k = 0; k < ALPHABET_SIZE; k++) begin
			if (wheel_fwd(w, 5'(k)) == i) o = 5'(k);
		end
		return o;
	endfunction

	function automatic logic [4:0] reflect(input logic [1:0] r, input logic [4:0] i);
		logic [1:0] sel;
		logic [7:0] ch;
		sel = (r == 2'd3) ? 2'd1 : r;
		ch = REFL_STR[sel][8*(ALPHABET_SIZE-1-int'(i)) +: 8];
		return 5'(ch - 8'd65);
	endfunction

	function automatic logic [4:0] rotor_pass(input logic [2:0] w, input logic [4:0] sh,
			input logic [4:0] c, input logic inverse);
		logic [4:0] idx;
		logic [4:0] o;
		idx = add26(c, sh);
		o = inverse ? wheel_inv(w, idx) : wheel_fwd(w, idx);
		return sub26(o, sh);
	endfunction

	function automatic logic at_notch(input logic [2:0] w, input logic [4:0] p);
		return (p == TURN_A[w]) || (p == TURN_B[w]);
	endfunction

	// later pairs override earlier ones, as on a board rewired in order
	function automatic logic [4:0] plug(input logic [49:0] pa, input logic [49:0] pb,
			input logic [4:0] c);
		logic [4:0] m;
		logic [49:0] r;
		logic [4:0] x;
		logic [4:0] y;
		m = c;
		for (int i = 0; i < 10; i++) begin
			r = (i < 5) ? pa : pb;
			x = r[10*(i%5) +: 5];
			y = r[10*(i%5)+5 +: 5];
			if (x <= LAST_LETTER && y <= LAST_LETTER && x != y) begin
				if (x == c) m = y;
				else if (y == c) m = x;
			end
		end
		return m;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/erc_in_if.sv =====
// Input channel: op and symbol beats
`timescale 1ns / 1ps
`default_nettype none
interface erc_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [4:0] symbol;

	modport source(output valid, output op, output symbol, input ready);
	modport sink(input valid, input op, input symbol, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/erc_out_if.sv =====
// Output channel: enciphered symbol and window letters
`timescale 1ns / 1ps
`default_nettype none
interface erc_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  cipher_symbol;
	logic [14:0] window_letters;

	modport source(output valid, output cipher_symbol, output window_letters, input ready);
	modport sink(input valid, input cipher_symbol, input window_letters, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/erc_queue.sv =====
// Short register queue between the stepping front and the substitution back
`timescale 1ns / 1ps
`default_nettype none
module erc_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire erc_pkg::erc_item_t push_item,
	input  wire logic              pop,
	output logic                   not_full,
	output logic                   not_empty,
	output erc_pkg::erc_item_t     head
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	erc_pkg::erc_item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign not_full  = (count_q != CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop) count_q <= CNT_W'(count_q + 1'b1);
			else if (do_pop && !do_push) count_q <= CNT_W'(count_q - 1'b1);
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/erc_front.sv =====
// Front: accepts beats, steps the rotors and works out per-rotor offsets
`timescale 1ns / 1ps
`default_nettype none
module erc_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire erc_pkg::erc_cfg_t cfg,
	erc_in_if.sink                 symbols,
	input  wire logic              queue_ready,
	output logic                   push,
	output erc_pkg::erc_item_t     item
);
	logic [4:0] pos_q [erc_pkg::ROTOR_COUNT];
	logic [4:0] pos_nxt [erc_pkg::ROTOR_COUNT];
	logic letter;
	logic mid_n;
	logic right_n;

	assign symbols.ready = queue_ready;
	assign push   = symbols.valid && queue_ready;
	assign letter = (symbols.op == erc_pkg::OP_CIPHER) && (symbols.symbol <= erc_pkg::LAST_LETTER);
	assign mid_n   = erc_pkg::at_notch(cfg.wheel_order[5:3], pos_q[1]);
	assign right_n = erc_pkg::at_notch(cfg.wheel_order[2:0], pos_q[2]);

	always_comb begin
		for (int s = 0; s < erc_pkg::ROTOR_COUNT; s++) pos_nxt[s] = pos_q[s];
		if (symbols.op == erc_pkg::OP_RELOAD) begin
			for (int s = 0; s < erc_pkg::ROTOR_COUNT; s++)
				pos_nxt[s] = erc_pkg::fold26(
					cfg.start_positions[5*(erc_pkg::ROTOR_COUNT-1-s) +: 5]);
		end else if (letter) begin
			if (mid_n) begin
				pos_nxt[0] = erc_pkg::inc26(pos_q[0]);
				pos_nxt[1] = erc_pkg::inc26(pos_q[1]);
			end else if (right_n) begin
				pos_nxt[1] = erc_pkg::inc26(pos_q[1]);
			end
			pos_nxt[2] = erc_pkg::inc26(pos_q[2]);
		end
	end

	always_comb begin
		item.letter  = letter;
		item.symbol  = symbols.symbol;
		item.windows = {pos_nxt[0], pos_nxt[1], pos_nxt[2]};
		for (int s = 0; s < erc_pkg::ROTOR_COUNT; s++)
			item.shift[s] = erc_pkg::sub26(pos_nxt[s], erc_pkg::fold26(
				cfg.ring_settings[5*(erc_pkg::ROTOR_COUNT-1-s) +: 5]));
	end

	// reset value of start_positions is all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < erc_pkg::ROTOR_COUNT; s++) pos_q[s] <= 5'd0;
		end else if (push) begin
			for (int s = 0; s < erc_pkg::ROTOR_COUNT; s++) pos_q[s] <= pos_nxt[s];
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/erc_back.sv =====
// Back: six-stage substitution pipeline, last stage is the output register
`timescale 1ns / 1ps
`default_nettype none
module erc_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire erc_pkg::erc_cfg_t cfg,
	input  wire logic              head_valid,
	input  wire erc_pkg::erc_item_t head,
	output logic                   pop,
	erc_out_if.source              results
);
	typedef struct packed {
		logic        letter;
		logic [4:0]  c;
		logic [14:0] windows;
		logic [erc_pkg::ROTOR_COUNT-1:0][4:0] shift;
	} stage_t;

	logic [2:0] w_l;
	logic [2:0] w_m;
	logic [2:0] w_r;
	logic adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	stage_t st_s1, st_s2, st_s3, st_s4, st_s5;
	logic [4:0]  cipher_s6;
	logic [14:0] windows_s6;

	assign w_l = cfg.wheel_order[8:6];
	assign w_m = cfg.wheel_order[5:3];
	assign w_r = cfg.wheel_order[2:0];
	assign adv = !v_s6 || results.ready;
	assign pop = adv && head_valid;

	assign results.valid          = v_s6;
	assign results.cipher_symbol  = cipher_s6;
	assign results.window_letters = windows_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= head_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// plugboard in, right rotor forward
			st_s1.letter  <= head.letter;
			st_s1.windows <= head.windows;
			st_s1.shift   <= head.shift;
			st_s1.c <= erc_pkg::rotor_pass(w_r, head.shift[2],
				erc_pkg::plug(cfg.plug_pairs_a, cfg.plug_pairs_b, head.symbol), 1'b0);
			// middle forward
			st_s2.letter  <= st_s1.letter;
			st_s2.windows <= st_s1.windows;
			st_s2.shift   <= st_s1.shift;
			st_s2.c <= erc_pkg::rotor_pass(w_m, st_s1.shift[1], st_s1.c, 1'b0);
			// left forward, reflector
			st_s3.letter  <= st_s2.letter;
			st_s3.windows <= st_s2.windows;
			st_s3.shift   <= st_s2.shift;
			st_s3.c <= erc_pkg::reflect(cfg.reflector_select,
				erc_pkg::rotor_pass(w_l, st_s2.shift[0], st_s2.c, 1'b0));
			// left inverse
			st_s4.letter  <= st_s3.letter;
			st_s4.windows <= st_s3.windows;
			st_s4.shift   <= st_s3.shift;
			st_s4.c <= erc_pkg::rotor_pass(w_l, st_s3.shift[0], st_s3.c, 1'b1);
			// middle inverse
			st_s5.letter  <= st_s4.letter;
			st_s5.windows <= st_s4.windows;
			st_s5.shift   <= st_s4.shift;
			st_s5.c <= erc_pkg::rotor_pass(w_m, st_s4.shift[1], st_s4.c, 1'b1);
			// right inverse, plugboard out
			windows_s6 <= st_s5.windows;
			cipher_s6  <= st_s5.letter
				? erc_pkg::plug(cfg.plug_pairs_a, cfg.plug_pairs_b,
					erc_pkg::rotor_pass(w_r, st_s5.shift[2], st_s5.c, 1'b1))
				: erc_pkg::SPACE_CODE;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/enigma_rotor_cipher.sv =====
// An accepted input beat passes through the queue, then the substitution pipeline.
// Throughput: one beat per cycle while the queue has room; the front steps the rotors
// on accept; the six-stage pipeline takes a beat every cycle unless the output stalls.
// Reset (arst_n low, asynchronous): rotors at window letters 0, queue and pipeline empty,
// configuration registers back to their reset values (wheels I II III, reflector B).
`timescale 1ns / 1ps
`default_nettype none
`include "enigma_rotor_cipher_macros.svh"
module enigma_rotor_cipher #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [49:0] cfg_wdata,
	erc_in_if.sink           symbols,
	erc_out_if.source        results
);
	erc_pkg::erc_cfg_t cfg_q;
	erc_pkg::erc_item_t push_item;
	erc_pkg::erc_item_t head;
	logic push;
	logic pop;
	logic not_full;
	logic not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wheel_order      <= 9'd10;
			cfg_q.reflector_select <= 2'd1;
			cfg_q.ring_settings    <= '0;
			cfg_q.start_positions  <= '0;
			cfg_q.plug_pairs_a     <= '0;
			cfg_q.plug_pairs_b     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				erc_pkg::CFG_WHEEL_ORDER:      cfg_q.wheel_order      <= cfg_wdata[8:0];
				erc_pkg::CFG_REFLECTOR_SELECT: cfg_q.reflector_select <= cfg_wdata[1:0];
				erc_pkg::CFG_RING_SETTINGS:    cfg_q.ring_settings    <= cfg_wdata[14:0];
				erc_pkg::CFG_START_POSITIONS:  cfg_q.start_positions  <= cfg_wdata[14:0];
				erc_pkg::CFG_PLUG_PAIRS_A:     cfg_q.plug_pairs_a     <= cfg_wdata;
				erc_pkg::CFG_PLUG_PAIRS_B:     cfg_q.plug_pairs_b     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	erc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.symbols     (symbols),
		.queue_ready (not_full),
		.push        (push),
		.item        (push_item)
	);

	erc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.not_full  (not_full),
		.not_empty (not_empty),
		.head      (head)
	);

	erc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (not_empty),
		.head       (head),
		.pop        (pop),
		.results    (results)
	);

	`ERC_ASSERT_IMP(a_cipher_range, results.valid, results.cipher_symbol <= erc_pkg::SPACE_CODE)
	`ERC_ASSERT_IMP(a_window_range, results.valid, (results.window_letters[14:10] <= erc_pkg::LAST_LETTER) && (results.window_letters[9:5] <= erc_pkg::LAST_LETTER) && (results.window_letters[4:0] <= erc_pkg::LAST_LETTER))
	`ERC_ASSERT_IMP(a_reload_windows, push && (symbols.op == erc_pkg::OP_RELOAD), (push_item.windows[14:10] == erc_pkg::fold26(cfg_q.start_positions[14:10])) && (push_item.windows[9:5] == erc_pkg::fold26(cfg_q.start_positions[9:5])) && (push_item.windows[4:0] == erc_pkg::fold26(cfg_q.start_positions[4:0])))
	`ERC_ASSERT_HOLD(a_no_push_when_full, !(push && !not_full))
endmodule
`default_nettype wire
